@@ hdl/rzn_pkg.sv @@
package rzn_pkg;

  localparam int ACC_W       = 64;
  localparam int NUM_VALS    = 5;
  localparam int IDX_W       = 3;
  localparam int FIELD_W     = 32;
  localparam int STEP_W      = 7;
  localparam int DIV_STEPS   = 64;
  localparam int SQRT_STEPS  = 32;
  localparam int FRAC_BITS_D   = 16;
  localparam int VALUE_WIDTH_D = 32;
  localparam int COUNT_WIDTH_D = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ACC, S_CNT, S_CHK,
    S_MEAN, S_MEAN_W, S_MSQ, S_MSQ_W, S_SQRT, S_SQRT_W, S_SDCHK,
    S_Z, S_Z_W, S_FIN, S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_rsp_t;

endpackage

@@ hdl/rzn_iter_unit.sv @@
// Shared restoring shift/subtract unit: one quotient or root bit per cycle.
module rzn_iter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  rzn_pkg::iu_req_t             req,
  input  logic [rzn_pkg::ACC_W-1:0]    num,
  input  logic [rzn_pkg::ACC_W-1:0]    den,
  output rzn_pkg::iu_rsp_t             rsp,
  output logic [rzn_pkg::ACC_W-1:0]    quo
);

  localparam int RW = rzn_pkg::ACC_W + 2;

  logic [RW-1:0]               rem;
  logic [rzn_pkg::ACC_W-1:0]   sh;
  logic [rzn_pkg::ACC_W-1:0]   dv;
  logic [rzn_pkg::STEP_W-1:0]  cnt;
  logic                        busy;
  logic                        mode;
  logic                        done;
  logic [RW-1:0]               shifted;
  logic [RW-1:0]               trial;
  logic                        ge;

  always_comb begin
    if (mode) begin
      shifted = {rem[RW-3:0], sh[rzn_pkg::ACC_W-1 -: 2]};
      trial   = {quo, 2'b01};
    end else begin
      shifted = {rem[RW-2:0], sh[rzn_pkg::ACC_W-1]};
      trial   = {2'b00, dv};
    end
    ge = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == rzn_pkg::STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == rzn_pkg::STEP_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= '0;
      sh   <= num;
      dv   <= den;
      mode <= req.sqrt_mode;
      cnt  <= req.sqrt_mode ? rzn_pkg::STEP_W'(rzn_pkg::SQRT_STEPS)
                            : rzn_pkg::STEP_W'(rzn_pkg::DIV_STEPS);
    end else if (busy) begin
      rem <= ge ? shifted - trial : shifted;
      quo <= {quo[rzn_pkg::ACC_W-2:0], ge};
      sh  <= mode ? {sh[rzn_pkg::ACC_W-3:0], 2'b00} : {sh[rzn_pkg::ACC_W-2:0], 1'b0};
      cnt <= cnt - rzn_pkg::STEP_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

@@ hdl/running_zscore_normalizer.sv @@
// Running z-score normalizer. Each transfer on the input carries a row of five signed
// fixed-point values; they are folded into running sum, sum-of-squares and count
// accumulators that only reset clears. The row then yields the z-score of each value
// against the running mean and population stdev: nonzero z-scores only, numbered from 1,
// the final one marked last; a row with none gives one result with index 0. A zero stdev
// or a saturated accumulator gives one result with degenerate set. After accumulating, a
// full row uses the single shared shift/subtract unit for each divide (start, 64 quotient
// bits, done) and for the square root (start, 32 root bits, done): two divides by the count,
// one root and five z-score divides, then up to five results are emitted, each subject to
// output stalls. in_ready is high only while no row is in progress.
module running_zscore_normalizer #(
  parameter int FRAC_BITS   = rzn_pkg::FRAC_BITS_D,
  parameter int VALUE_WIDTH = rzn_pkg::VALUE_WIDTH_D,
  parameter int COUNT_WIDTH = rzn_pkg::COUNT_WIDTH_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] val_a,
  input  logic [31:0] val_t,
  input  logic [31:0] val_c,
  input  logic [31:0] val_g,
  input  logic [31:0] val_score,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  feature_index,
  output logic [31:0] z_value,
  output logic        degenerate,
  output logic        last
);

  localparam int AW = rzn_pkg::ACC_W;
  localparam int IW = rzn_pkg::IDX_W;
  localparam logic signed [AW-1:0] SUM_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] SUM_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [AW-1:0] ZMAX = AW'((64'(1) << (VALUE_WIDTH - 1)) - 64'(1));

  rzn_pkg::state_t state, state_next;
  rzn_pkg::iu_req_t iu_req;
  rzn_pkg::iu_rsp_t iu_rsp;
  logic [AW-1:0] iu_num, iu_den, iu_quo;

  logic signed [VALUE_WIDTH-1:0] vals [rzn_pkg::NUM_VALS];
  logic [31:0]                   zs   [rzn_pkg::NUM_VALS];
  logic signed [AW-1:0]          total_sum;
  logic [AW-1:0]                 total_square_sum;
  logic [COUNT_WIDTH-1:0]        value_count;
  logic [AW-1:0]                 sq;
  logic signed [AW-1:0]          mean;
  logic [AW-1:0]                 msq;
  logic [31:0]                   sd;
  logic                          dneg;
  logic [IW-1:0]                 idx, n_cnt, k;
  logic                          one_deg;

  logic signed [VALUE_WIDTH-1:0] cur;
  logic signed [AW-1:0]          cur64;
  logic [VALUE_WIDTH-1:0]        cmag;
  logic [2*VALUE_WIDTH-1:0]      cprod;
  logic signed [AW:0]            sum_ext;
  logic [AW:0]                   sq_ext;
  logic signed [AW-1:0]          d;
  logic [AW-1:0]                 dmag;
  logic [AW-1:0]                 amean64;
  logic [VALUE_WIDTH-1:0]        amean;
  logic [2*VALUE_WIDTH-1:0]      mprod;
  logic [AW-1:0]                 var_v;
  logic signed [AW-1:0]          z;
  logic                          sum_sat, degen, ofree, load_one, load_emit;

  assign in_ready = (state == rzn_pkg::S_IDLE);
  assign ofree    = !out_valid || out_ready;

  always_comb begin
    cur     = vals[idx];
    cur64   = AW'(cur);
    cmag    = cur[VALUE_WIDTH-1] ? VALUE_WIDTH'(-cur) : cur;
    cprod   = (2*VALUE_WIDTH)'(cmag) * (2*VALUE_WIDTH)'(cmag);
    sum_sat = (total_sum == SUM_MAX) || (total_sum == SUM_MIN);
    sum_ext = {total_sum[AW-1], total_sum} + {cur64[AW-1], cur64};
    sq_ext  = {1'b0, total_square_sum} + {1'b0, sq};
    degen   = (value_count == CNT_MAX) || sum_sat || (total_square_sum == '1);
    d       = cur64 - mean;
    dmag    = d[AW-1] ? AW'(-d) : AW'(d);
    amean64 = mean[AW-1] ? AW'(-mean) : AW'(mean);
    amean   = amean64[VALUE_WIDTH-1:0];
    mprod   = (2*VALUE_WIDTH)'(amean) * (2*VALUE_WIDTH)'(amean);
    var_v   = (iu_quo > msq) ? iu_quo - msq : '0;
    if (dneg) begin
      z = (iu_quo > ZMAX + AW'(1)) ? -$signed(ZMAX) - AW'(1) : -$signed(iu_quo);
    end else begin
      z = (iu_quo > ZMAX) ? $signed(ZMAX) : $signed(iu_quo);
    end
  end

  always_comb begin
    state_next       = state;
    iu_req.start     = 1'b0;
    iu_req.sqrt_mode = 1'b0;
    iu_num           = '0;
    iu_den           = AW'(value_count);
    load_one         = 1'b0;
    load_emit        = 1'b0;
    case (state)
      rzn_pkg::S_IDLE:   if (in_valid) state_next = rzn_pkg::S_SQ;
      rzn_pkg::S_SQ:     state_next = rzn_pkg::S_ACC;
      rzn_pkg::S_ACC:    state_next = (idx == IW'(rzn_pkg::NUM_VALS - 1)) ? rzn_pkg::S_CNT
                                                                         : rzn_pkg::S_SQ;
      rzn_pkg::S_CNT:    state_next = rzn_pkg::S_CHK;
      rzn_pkg::S_CHK:    state_next = degen ? rzn_pkg::S_FIN : rzn_pkg::S_MEAN;
      rzn_pkg::S_MEAN: begin
        iu_req.start = 1'b1;
        iu_num       = total_sum[AW-1] ? AW'(-total_sum) : AW'(total_sum);
        state_next   = rzn_pkg::S_MEAN_W;
      end
      rzn_pkg::S_MEAN_W: if (iu_rsp.done) state_next = rzn_pkg::S_MSQ;
      rzn_pkg::S_MSQ: begin
        iu_req.start = 1'b1;
        iu_num       = total_square_sum;
        state_next   = rzn_pkg::S_MSQ_W;
      end
      rzn_pkg::S_MSQ_W:  if (iu_rsp.done) state_next = rzn_pkg::S_SQRT;
      rzn_pkg::S_SQRT: begin
        iu_req.start     = 1'b1;
        iu_req.sqrt_mode = 1'b1;
        iu_num           = var_v << FRAC_BITS;
        state_next       = rzn_pkg::S_SQRT_W;
      end
      rzn_pkg::S_SQRT_W: if (iu_rsp.done) state_next = rzn_pkg::S_SDCHK;
      rzn_pkg::S_SDCHK:  state_next = (sd == '0) ? rzn_pkg::S_FIN : rzn_pkg::S_Z;
      rzn_pkg::S_Z: begin
        iu_req.start = 1'b1;
        iu_num       = dmag << FRAC_BITS;
        iu_den       = AW'(sd);
        state_next   = rzn_pkg::S_Z_W;
      end
      rzn_pkg::S_Z_W: begin
        if (iu_rsp.done) begin
          state_next = (idx == IW'(rzn_pkg::NUM_VALS - 1)) ? rzn_pkg::S_FIN : rzn_pkg::S_Z;
        end
      end
      rzn_pkg::S_FIN: begin
        if (one_deg || n_cnt == '0) begin
          if (ofree) begin
            load_one   = 1'b1;
            state_next = rzn_pkg::S_IDLE;
          end
        end else begin
          state_next = rzn_pkg::S_EMIT;
        end
      end
      rzn_pkg::S_EMIT: begin
        if (ofree) begin
          load_emit = 1'b1;
          if (k == n_cnt - IW'(1)) state_next = rzn_pkg::S_IDLE;
        end
      end
      default: state_next = rzn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rzn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // running accumulators: cleared only by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      total_sum        <= '0;
      total_square_sum <= '0;
      value_count      <= '0;
    end else begin
      if (state == rzn_pkg::S_SQ && !sum_sat) begin
        if (sum_ext[AW] != sum_ext[AW-1]) begin
          total_sum <= sum_ext[AW] ? SUM_MIN : SUM_MAX;
        end else begin
          total_sum <= sum_ext[AW-1:0];
        end
      end
      if (state == rzn_pkg::S_ACC) begin
        total_square_sum <= sq_ext[AW] ? '1 : sq_ext[AW-1:0];
      end
      if (state == rzn_pkg::S_CNT) begin
        if (value_count > CNT_MAX - COUNT_WIDTH'(rzn_pkg::NUM_VALS)) begin
          value_count <= CNT_MAX;
        end else begin
          value_count <= value_count + COUNT_WIDTH'(rzn_pkg::NUM_VALS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      n_cnt   <= '0;
      k       <= '0;
      one_deg <= 1'b0;
    end else begin
      case (state)
        rzn_pkg::S_IDLE: begin
          idx     <= '0;
          n_cnt   <= '0;
          k       <= '0;
          one_deg <= 1'b0;
        end
        rzn_pkg::S_ACC: idx <= (idx == IW'(rzn_pkg::NUM_VALS - 1)) ? '0 : idx + IW'(1);
        rzn_pkg::S_CHK: one_deg <= degen;
        rzn_pkg::S_SDCHK: one_deg <= (sd == '0);
        rzn_pkg::S_Z_W: begin
          if (iu_rsp.done) begin
            idx <= idx + IW'(1);
            if (z != '0) n_cnt <= n_cnt + IW'(1);
          end
        end
        rzn_pkg::S_EMIT: if (ofree) k <= k + IW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rzn_pkg::S_IDLE && in_valid) begin
      vals[0] <= val_a[VALUE_WIDTH-1:0];
      vals[1] <= val_t[VALUE_WIDTH-1:0];
      vals[2] <= val_c[VALUE_WIDTH-1:0];
      vals[3] <= val_g[VALUE_WIDTH-1:0];
      vals[4] <= val_score[VALUE_WIDTH-1:0];
    end
    if (state == rzn_pkg::S_SQ) sq <= AW'(cprod >> FRAC_BITS);
    if (state == rzn_pkg::S_MEAN_W && iu_rsp.done) begin
      mean <= total_sum[AW-1] ? -$signed(iu_quo) : $signed(iu_quo);
    end
    if (state == rzn_pkg::S_MSQ) msq <= AW'(mprod >> FRAC_BITS);
    if (state == rzn_pkg::S_SQRT_W && iu_rsp.done) sd <= iu_quo[31:0];
    if (state == rzn_pkg::S_Z) dneg <= d[AW-1];
    if (state == rzn_pkg::S_Z_W && iu_rsp.done && z != '0) zs[n_cnt] <= z[31:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_one || load_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_one) begin
      feature_index <= '0;
      z_value       <= '0;
      degenerate    <= one_deg;
      last          <= 1'b1;
    end else if (load_emit) begin
      feature_index <= k + IW'(1);
      z_value       <= zs[k];
      degenerate    <= 1'b0;
      last          <= (k == n_cnt - IW'(1));
    end
  end

  rzn_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (iu_req),
    .num (iu_num),
    .den (iu_den),
    .rsp (iu_rsp),
    .quo (iu_quo)
  );

`ifndef SYNTH
  a_nz_bound: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= IW'(rzn_pkg::NUM_VALS))
    else $error("z-score count past five");
  a_deg_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> feature_index == '0 && z_value == '0 && last)
    else $error("degenerate result carries data");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && feature_index == '0 |-> last)
    else $error("empty marker without last");
  a_iu_start_idle: assert property (@(posedge clk) disable iff (rst)
    iu_req.start |-> !iu_rsp.busy)
    else $error("shared unit restarted while busy");
`endif

endmodule
